// ===== rtl/core/dlq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Delta-list timer queue package
// Shared entry layout, cell operation codes, function and status codes.
// ----------------------------------------------------------------------------
package dlq_pkg;

  localparam int DELTA_W = 32;
  localparam int ID_W    = 16;

  typedef enum logic [1:0] {
    FUNC_TICK     = 2'd0,
    FUNC_ADD      = 2'd1,
    FUNC_DELETE   = 2'd2,
    FUNC_DISPATCH = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_READY = 2'd3
  } status_t;

  // Per-cell operation code.
  typedef enum logic [2:0] {
    OP_HOLD       = 3'd0,
    OP_TICK       = 3'd1,
    OP_LOAD_LEFT  = 3'd2,
    OP_LOAD_RIGHT = 3'd3,
    OP_LOAD_NEW   = 3'd4,
    OP_FOLD       = 3'd5,
    OP_SET_DELTA  = 3'd6
  } cell_op_t;

  typedef struct packed {
    logic               used;
    logic               ready;
    logic [DELTA_W-1:0] delta;
    logic [DELTA_W-1:0] period;
    logic [ID_W-1:0]    id;
  } entry_t;

  typedef struct packed {
    cell_op_t           op;
    logic [DELTA_W-1:0] set_delta;
  } cell_ctl_t;

endpackage : dlq_pkg
`default_nettype wire

// ===== rtl/core/delta_list_task_timer_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Delta-list task timer queue
// Sorted timer queue held in a row of cells, each entry storing its delay
// relative to the entry in front of it.
// ----------------------------------------------------------------------------
//  channel   direction  tdata bits  contents
//  s_axis    in         96          func, task_handle, first_delay,
//                                   repeat_period, target_id
//  m_axis    out        32          status, result_id, fired, fired_handle
//
// An add walks the used entries one per cycle before it inserts; a delete
// likewise searches one entry per cycle before a shift in the remove state.
// A dispatch of a periodic task adds the re-insertion walk. Reset clears
// every cell and the ID counter. A new item is taken only when the block is
// idle; a finished result waits in the output register, and the block holds
// in its final state until that is free.
// ----------------------------------------------------------------------------
module delta_list_task_timer_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int HANDLE_BITS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // func[1:0], task_handle[9:2], first_delay[41:10], repeat_period[73:42],
  // target_id[89:74], zero fill
  input  wire logic [95:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // status[1:0], result_id[17:2], fired[18], fired_handle[26:19], zero fill
  output logic [31:0]      m_tdata
);
  import dlq_pkg::*;

  localparam int IW = $clog2(QUEUE_DEPTH + 1);
  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_EXEC     = 7'b0000010,
    S_WALK_ADD = 7'b0000100,
    S_INSERT   = 7'b0001000,
    S_WALK_DEL = 7'b0010000,
    S_REMOVE   = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_t;

  state_t                 state, state_next;

  // Latched input item.
  func_t                  func;
  logic [HANDLE_BITS-1:0] handle;
  logic [DELTA_W-1:0]     delay;
  logic [DELTA_W-1:0]     period;
  logic [ID_W-1:0]        target;
  logic                   readd;

  logic [IW-1:0]          idx;
  logic [PW-1:0]          pos;
  logic [DELTA_W:0]       sum;
  logic [DELTA_W-1:0]     new_delta;
  logic [ID_W-1:0]        id_counter;
  logic [ID_W-1:0]        id_inc;

  status_t                res_status;
  logic [ID_W-1:0]        res_id;
  logic                   res_fired;
  logic [7:0]             res_handle;

  entry_t                 cell_q      [QUEUE_DEPTH];
  logic [HANDLE_BITS-1:0] cell_h      [QUEUE_DEPTH];
  cell_ctl_t              cell_ctl    [QUEUE_DEPTH];
  entry_t                 fresh;
  logic [QUEUE_DEPTH-1:0] used_vec;

  entry_t                 cur;
  logic [DELTA_W:0]       walk_sum;
  logic                   in_range;

  assign s_tready = (state == S_IDLE);
  assign id_inc   = (id_counter + 1'b1 == '0) ? ID_W'(1) : id_counter + 1'b1;
  assign in_range = (idx < IW'(QUEUE_DEPTH));
  assign cur      = in_range ? cell_q[idx[PW-1:0]] : '0;
  assign walk_sum = sum + {1'b0, cur.delta};

  always_comb begin
    fresh        = '0;
    fresh.used   = 1'b1;
    fresh.ready  = (new_delta == '0);
    fresh.delta  = new_delta;
    fresh.period = period;
    fresh.id     = id_inc;
  end

  // Cell row.
  for (genvar j = 0; j < QUEUE_DEPTH; j++) begin : g_cell
    entry_t                 l_e, r_e;
    logic [HANDLE_BITS-1:0] l_h, r_h;
    if (j == 0) begin : g_first
      assign l_e = '0;
      assign l_h = '0;
    end else begin : g_mid
      assign l_e = cell_q[j-1];
      assign l_h = cell_h[j-1];
    end
    if (j == QUEUE_DEPTH - 1) begin : g_last
      assign r_e = '0;
      assign r_h = '0;
    end else begin : g_inner
      assign r_e = cell_q[j+1];
      assign r_h = cell_h[j+1];
    end
    assign used_vec[j] = cell_q[j].used;

    dlq_cell #(.HANDLE_BITS(HANDLE_BITS)) u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctl          (cell_ctl[j]),
      .left         (l_e),
      .left_handle  (l_h),
      .right        (r_e),
      .right_handle (r_h),
      .fresh        (fresh),
      .fresh_handle (handle),
      .q            (cell_q[j]),
      .q_handle     (cell_h[j])
    );
  end

  // Per-cell control.
  always_comb begin
    for (int j = 0; j < QUEUE_DEPTH; j++) begin
      cell_ctl[j].op        = OP_HOLD;
      cell_ctl[j].set_delta = DELTA_W'(walk_sum - {1'b0, delay});
      unique case (state)
        S_EXEC: begin
          if (func == FUNC_TICK && j == 0) cell_ctl[j].op = OP_TICK;
        end
        S_WALK_ADD: begin
          if (in_range && cur.used && walk_sum > {1'b0, delay} &&
              PW'(j) == idx[PW-1:0]) cell_ctl[j].op = OP_SET_DELTA;
        end
        S_INSERT: begin
          if (PW'(j) == pos)     cell_ctl[j].op = OP_LOAD_NEW;
          else if (PW'(j) > pos) cell_ctl[j].op = OP_LOAD_LEFT;
        end
        S_REMOVE: begin
          if (PW'(j) == pos)     cell_ctl[j].op = OP_FOLD;
          else if (PW'(j) > pos) cell_ctl[j].op = OP_LOAD_RIGHT;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (s_tvalid) state_next = S_EXEC;
      S_EXEC: begin
        unique case (func)
          FUNC_TICK:   state_next = S_DONE;
          FUNC_ADD:    state_next = used_vec[QUEUE_DEPTH-1] ? S_DONE : S_WALK_ADD;
          FUNC_DELETE: state_next = (target == '0) ? S_DONE : S_WALK_DEL;
          FUNC_DISPATCH:
            state_next = (cell_q[0].used && cell_q[0].ready) ? S_REMOVE : S_DONE;
          default:     state_next = S_DONE;
        endcase
      end
      S_WALK_ADD: begin
        if (!in_range || !cur.used || walk_sum > {1'b0, delay}) state_next = S_INSERT;
      end
      S_INSERT:   state_next = S_DONE;
      S_WALK_DEL: begin
        if (!in_range || !cur.used) state_next = S_DONE;
        else if (cur.id == target)  state_next = S_REMOVE;
      end
      S_REMOVE:   state_next = readd ? S_WALK_ADD : S_DONE;
      S_DONE:     if (!m_tvalid || m_tready) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      id_counter <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready)                  m_tvalid <= 1'b0;
      if (state == S_INSERT) id_counter <= id_inc;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          func   <= func_t'(s_tdata[1:0]);
          handle <= HANDLE_BITS'(32'(s_tdata[9:2]));
          delay  <= s_tdata[41:10];
          period <= s_tdata[73:42];
          target <= s_tdata[89:74];
        end
      end
      S_EXEC: begin
        res_status <= ST_OK;
        res_id     <= '0;
        res_fired  <= 1'b0;
        res_handle <= '0;
        readd      <= 1'b0;
        idx        <= '0;
        sum        <= '0;
        pos        <= '0;
        unique case (func)
          FUNC_ADD:    if (used_vec[QUEUE_DEPTH-1]) res_status <= ST_FULL;
          FUNC_DELETE: if (target == '0) res_status <= ST_NOT_FOUND;
          FUNC_DISPATCH: begin
            if (cell_q[0].used && cell_q[0].ready) begin
              res_id     <= cell_q[0].id;
              res_fired  <= 1'b1;
              res_handle <= 8'(32'(cell_h[0]));
              readd      <= (cell_q[0].period != '0);
              handle     <= cell_h[0];
              delay      <= cell_q[0].period;
              period     <= cell_q[0].period;
            end else begin
              res_status <= ST_NOT_READY;
            end
          end
          default: begin
          end
        endcase
      end
      S_WALK_ADD: begin
        if (!in_range || !cur.used) begin
          pos       <= idx[PW-1:0];
          new_delta <= delay - sum[DELTA_W-1:0];
        end else if (walk_sum > {1'b0, delay}) begin
          pos       <= idx[PW-1:0];
          new_delta <= delay - sum[DELTA_W-1:0];
        end else begin
          sum <= walk_sum;
          idx <= idx + 1'b1;
        end
      end
      S_INSERT: begin
        if (func == FUNC_ADD) res_id <= id_inc;
      end
      S_WALK_DEL: begin
        if (!in_range || !cur.used) res_status <= ST_NOT_FOUND;
        else if (cur.id == target)  pos <= idx[PW-1:0];
        else                        idx <= idx + 1'b1;
      end
      S_REMOVE: begin
        idx <= '0;
        sum <= '0;
      end
      S_DONE: begin
        if (!m_tvalid || m_tready)
          m_tdata <= {5'd0, res_handle, res_fired, res_id, res_status};
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  // Used entries sit together from the head whenever the block is idle.
  a_contiguous: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> ((used_vec + 1'b1) & used_vec) == '0)
    else $error("queue entries not contiguous");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_DONE))
    else $error("result raised outside the final state");

  a_fired_id: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[18] |-> m_tdata[17:2] != '0)
    else $error("dispatched task carries ID zero");
`endif

endmodule : delta_list_task_timer_queue
`default_nettype wire

// ===== rtl/core/dlq_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Delta-list timer queue cell
// Holds one queue entry; can shift from either neighbour, load a new entry, count down, set its delay, or
// fold the delay of a removed entry into its right neighbour.
// ----------------------------------------------------------------------------
module dlq_cell #(
  parameter int HANDLE_BITS = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire dlq_pkg::cell_ctl_t     ctl,
  input  wire dlq_pkg::entry_t        left,
  input  wire logic [HANDLE_BITS-1:0] left_handle,
  input  wire dlq_pkg::entry_t        right,
  input  wire logic [HANDLE_BITS-1:0] right_handle,
  input  wire dlq_pkg::entry_t        fresh,
  input  wire logic [HANDLE_BITS-1:0] fresh_handle,
  output dlq_pkg::entry_t             q,
  output logic [HANDLE_BITS-1:0]      q_handle
);
  import dlq_pkg::*;

  entry_t                 q_next;
  logic [HANDLE_BITS-1:0] handle_next;
  logic [DELTA_W:0]       fold_sum;
  logic [DELTA_W-1:0]     dec;

  always_comb begin
    q_next      = q;
    handle_next = q_handle;
    fold_sum    = {1'b0, right.delta} + {1'b0, q.delta};
    dec         = (q.delta != '0) ? q.delta - 1'b1 : q.delta;
    unique case (ctl.op)
      OP_HOLD: begin
      end
      OP_TICK: begin
        if (q.used && !q.ready) begin
          q_next.delta = dec;
          q_next.ready = (dec == '0);
        end
      end
      OP_LOAD_LEFT: begin
        q_next      = left;
        handle_next = left_handle;
      end
      OP_LOAD_RIGHT: begin
        q_next      = right;
        handle_next = right_handle;
      end
      OP_LOAD_NEW: begin
        q_next      = fresh;
        handle_next = fresh_handle;
      end
      OP_FOLD: begin
        // This entry leaves; its delay moves into the one that takes its place.
        q_next      = right;
        handle_next = right_handle;
        if (right.used) begin
          q_next.delta = fold_sum[DELTA_W] ? {DELTA_W{1'b1}} : fold_sum[DELTA_W-1:0];
          q_next.ready = right.ready && (q.delta == '0);
        end
      end
      OP_SET_DELTA: begin
        q_next.delta = ctl.set_delta;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q        <= '0;
      q_handle <= '0;
    end else begin
      q        <= q_next;
      q_handle <= handle_next;
    end
  end

endmodule : dlq_cell
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer queue testbench
// Drives random and directed tick, add, delete and dispatch items into the
// block, predicts every result with an independent model of the delta list
// and compares each returned item field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import dlq_pkg::*;

  localparam int DEPTH = 16;

  // One request item as the sender sees it.
  typedef struct {
    func_t       func;
    logic [7:0]  handle;
    logic [31:0] delay;
    logic [31:0] period;
    logic [15:0] target;
  } req_t;

  // One expected result item.
  typedef struct {
    status_t     status;
    logic [15:0] rid;
    logic        fired;
    logic [7:0]  fh;
  } resp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;

  delta_list_task_timer_queue dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the delta list.
  logic        q_used   [DEPTH];
  logic [7:0]  q_handle [DEPTH];
  logic [31:0] q_delta  [DEPTH];
  logic [31:0] q_period [DEPTH];
  logic        q_ready  [DEPTH];
  logic [15:0] q_id     [DEPTH];
  logic [15:0] id_seq;

  req_t  pending_reqs[$];
  resp_t awaited[$];
  int    errors = 0;
  int    n_sent = 0;
  int    n_checked = 0;
  int    n_fired = 0;
  bit    hold_sender = 1'b0;
  bit    taken = 1'b0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %0s: got %0h want %0h (result %0d)", what, got, want, n_checked);
    errors++;
  endtask

  function automatic int used_count();
    int n;
    n = 0;
    while (n < DEPTH && q_used[n]) n++;
    return n;
  endfunction

  function automatic void move_slot(int dst, int src);
    q_used[dst] = q_used[src];   q_handle[dst] = q_handle[src];
    q_delta[dst] = q_delta[src]; q_period[dst] = q_period[src];
    q_ready[dst] = q_ready[src]; q_id[dst] = q_id[src];
  endfunction

  function automatic void wipe_slot(int k);
    q_used[k] = 0; q_handle[k] = 0; q_delta[k] = 0;
    q_period[k] = 0; q_ready[k] = 0; q_id[k] = 0;
  endfunction

  function automatic logic [15:0] fresh_id();
    id_seq = id_seq + 16'd1;
    if (id_seq == 16'd0) id_seq = 16'd1;
    return id_seq;
  endfunction

  // Unlinks slot k; its delay is folded into the follower with saturation.
  function automatic void unlink(int k);
    int n;
    logic [32:0] s;
    n = used_count();
    if (k + 1 < n) begin
      s = {1'b0, q_delta[k + 1]} + {1'b0, q_delta[k]};
      q_delta[k + 1] = s[32] ? 32'hFFFF_FFFF : s[31:0];
      if (q_delta[k] != 0) q_ready[k + 1] = 1'b0;
    end
    for (int j = k; j + 1 < n; j++) move_slot(j, j + 1);
    wipe_slot(n - 1);
  endfunction

  // Walks the running sum; equal totals go behind the existing entries.
  function automatic logic [15:0] link(logic [7:0] h, logic [31:0] d, logic [31:0] p);
    int n, pos, i;
    logic [33:0] sum;
    logic [31:0] nd;
    n = used_count();
    pos = n;
    sum = '0;
    for (i = 0; i < n; i++) begin
      sum += q_delta[i];
      if (sum > d) break;
    end
    if (i < n) begin
      pos = i;
      nd = d - (sum[31:0] - q_delta[i]);
      q_delta[i] = sum[31:0] - d;
    end else begin
      nd = d - sum[31:0];
    end
    for (int j = n; j > pos; j--) move_slot(j, j - 1);
    q_used[pos] = 1'b1; q_handle[pos] = h; q_delta[pos] = nd;
    q_period[pos] = p; q_ready[pos] = (nd == 0); q_id[pos] = fresh_id();
    return q_id[pos];
  endfunction

  function automatic resp_t predict_timer(req_t r);
    resp_t o;
    logic [7:0]  h;
    logic [31:0] p;
    o = '{ST_OK, 16'd0, 1'b0, 8'd0};
    case (r.func)
      FUNC_TICK: begin
        if (q_used[0] && !q_ready[0]) begin
          if (q_delta[0] > 0) q_delta[0]--;
          if (q_delta[0] == 0) q_ready[0] = 1'b1;
        end
      end
      FUNC_ADD: begin
        if (used_count() >= DEPTH) o.status = ST_FULL;
        else o.rid = link(r.handle, r.delay, r.period);
      end
      FUNC_DELETE: begin
        o.status = ST_NOT_FOUND;
        if (r.target != 0) begin
          for (int k = 0; k < used_count(); k++) begin
            if (q_id[k] == r.target) begin
              unlink(k);
              o.status = ST_OK;
              break;
            end
          end
        end
      end
      default: begin
        if (q_used[0] && q_ready[0]) begin
          h = q_handle[0];
          p = q_period[0];
          o.rid = q_id[0];
          o.fired = 1'b1;
          o.fh = h;
          unlink(0);
          if (p != 0) void'(link(h, p, p));
        end else begin
          o.status = ST_NOT_READY;
        end
      end
    endcase
    return o;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  // Driver: items leave the pending queue; the model runs on acceptance.
  int send_gap = 0;

  req_t in_flight;
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      awaited.push_back(predict_timer(in_flight));
      n_sent++;
      taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !taken) begin
      // hold the item until the block takes it
    end else if (send_gap > 0) begin
      s_tvalid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (pending_reqs.size() != 0 && !hold_sender) begin
      in_flight = pending_reqs.pop_front();
      taken = 1'b0;
      s_tdata <= {6'd0, in_flight.target, in_flight.period, in_flight.delay,
                  in_flight.handle, in_flight.func};
      s_tvalid <= 1'b1;
      send_gap <= gap_len();
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // Receiver with random back-pressure, checked at the rising edge.
  int stall = 0;
  always @(negedge clk) begin
    if (stall > 0) begin
      m_tready <= 1'b0;
      stall <= stall - 1;
    end else begin
      m_tready <= 1'b1;
      stall <= gap_len();
    end
  end

  always @(posedge clk) begin
    resp_t w;
    if (!rst && m_tvalid && m_tready) begin
      if (awaited.size() == 0) begin
        report("unexpected item", m_tdata, 32'd0);
      end else begin
        w = awaited.pop_front();
        if (m_tdata[1:0] != w.status) report("status", m_tdata[1:0], w.status);
        if (m_tdata[17:2] != w.rid) report("result_id", m_tdata[17:2], w.rid);
        if (m_tdata[18] != w.fired) report("fired", m_tdata[18], w.fired);
        if (m_tdata[26:19] != w.fh) report("fired_handle", m_tdata[26:19], w.fh);
        if (w.fired) n_fired++;
      end
      n_checked++;
    end
  end

  function automatic req_t mk(func_t f, logic [7:0] h, logic [31:0] d,
                              logic [31:0] p, logic [15:0] t);
    req_t r;
    r.func = f; r.handle = h; r.delay = d; r.period = p; r.target = t;
    return r;
  endfunction

  // Random item; delays small mostly so ticks bring tasks due.
  function automatic req_t rand_req(logic [15:0] last_id);
    req_t r;
    int sel;
    r = mk(FUNC_TICK, $urandom(), $urandom(), $urandom(), $urandom());
    sel = $urandom_range(0, 99);
    if (sel < 40) r.func = FUNC_TICK;
    else if (sel < 65) r.func = FUNC_ADD;
    else if (sel < 80) r.func = FUNC_DELETE;
    else r.func = FUNC_DISPATCH;
    if ($urandom_range(0, 9) != 0) r.delay = $urandom_range(0, 12);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: r.period = 0;
      4: ;
      default: r.period = $urandom_range(1, 8);
    endcase
    if ($urandom_range(0, 3) != 0) r.target = last_id - $urandom_range(0, 12);
    return r;
  endfunction

  initial begin
    for (int k = 0; k < DEPTH; k++) wipe_slot(k);
    id_seq = 0;
    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed: empty-queue cases, zero and maximum delays, ties, full queue,
    // delete of ID zero and of an absent ID.
    pending_reqs.push_back(mk(FUNC_DISPATCH, 0, 0, 0, 0));
    pending_reqs.push_back(mk(FUNC_TICK, 0, 0, 0, 0));
    pending_reqs.push_back(mk(FUNC_DELETE, 0, 0, 0, 16'd0));
    pending_reqs.push_back(mk(FUNC_ADD, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
    pending_reqs.push_back(mk(FUNC_ADD, 8'h00, 32'd0, 32'd3, 0));
    pending_reqs.push_back(mk(FUNC_ADD, 8'h5A, 32'd2, 32'd0, 0));
    pending_reqs.push_back(mk(FUNC_ADD, 8'hA5, 32'd2, 32'd0, 0));
    pending_reqs.push_back(mk(FUNC_DISPATCH, 0, 0, 0, 0));
    pending_reqs.push_back(mk(FUNC_DELETE, 0, 0, 0, 16'hFFFF));
    for (int i = 0; i < 14; i++)
      pending_reqs.push_back(mk(FUNC_ADD, i, 32'hFFFF_FFF0 + i, 0, 0));
    pending_reqs.push_back(mk(FUNC_DELETE, 0, 0, 0, 16'd1));
    pending_reqs.push_back(mk(FUNC_TICK, 0, 0, 0, 0));
    while (pending_reqs.size() != 0 || s_tvalid || awaited.size() != 0) @(posedge clk);

    // Sender holds off while a delete for every remaining entry is queued.
    hold_sender = 1'b1;
    for (int k = 0; k < DEPTH; k++)
      if (q_used[k]) pending_reqs.push_back(mk(FUNC_DELETE, 0, 0, 0, q_id[k]));
    hold_sender = 1'b0;
    while (pending_reqs.size() != 0 || s_tvalid || awaited.size() != 0) @(posedge clk);

    for (int i = 0; i < 1450; i++) begin
      pending_reqs.push_back(rand_req(id_seq + 16'(pending_reqs.size() / 4)));
      if (i % 300 == 299) begin
        while (pending_reqs.size() != 0 || s_tvalid || awaited.size() != 0)
          @(posedge clk);
      end
    end
    while (pending_reqs.size() != 0 || s_tvalid || awaited.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("Sent %0d items, checked %0d results, %0d dispatches fired.",
             n_sent, n_checked, n_fired);
    if (errors == 0 && awaited.size() == 0)
      $display("** delta_list_task_timer_queue: PASSED **");
    else
      $display("** delta_list_task_timer_queue: FAILED **");
    $finish;
  end

  initial begin
    #2000000;
    $display("** delta_list_task_timer_queue: FAILED **");
    $finish;
  end

endmodule
